// File: rtl/aapa_pkg.sv
// Shared types and constants for the bulk-assign / point-add table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aapa_pkg;

   localparam int DEPTH_DEF  = 1024;
   localparam int INDEX_W    = 10;
   localparam int OPERAND_W  = 32;
   localparam int VALUE_W    = 64;
   localparam int REQ_DATA_W = 48;
   localparam int EPOCH_W    = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ASSIGN = 2'd1,
      OP_ADD    = 2'd2,
      OP_QUERY  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic do_exec;
      logic clear_step;
   } ctl_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       out_free;
      logic       clear_done;
      logic       epoch_wrap;
   } dp_status_type;

endpackage

// File: rtl/aapa_ctrl.sv
// Controller FSM: sequences tag clearing, item capture and execution.
// Depends on aapa_pkg; drives the datapath through ctl_cmd_type.
`timescale 1ns / 1ps

module aapa_ctrl
   import aapa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op != OP_QUERY || status.out_free) begin
               cmd.do_exec = 1'b1;
               if (status.op == OP_ASSIGN && status.epoch_wrap) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_EXEC)
      else $error("capture not followed by execute");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_tready && !cmd.do_exec)
      else $error("item handled during clearing pass");

   a_wrap_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.do_exec && status.op == OP_ASSIGN && status.epoch_wrap |=> state_ff == ST_CLEAR)
      else $error("epoch wrap without clearing pass");

endmodule

// File: rtl/aapa_dp.sv
// Datapath: initial and delta memories with epoch tags, base register,
// 64-bit adders and the result register. Depends on aapa_pkg.
`timescale 1ns / 1ps

module aapa_dp
   import aapa_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_W-1:0]    rsp_tdata,
   input  ctl_cmd_type           cmd,
   output dp_status_type         status
);

   localparam int AW = $clog2(DEPTH);
   localparam int DW = VALUE_W + EPOCH_W;

   logic [VALUE_W-1:0] init_mem [DEPTH];
   logic [DW-1:0]      delta_mem [DEPTH];

   opcode_type           op_ff;
   logic [AW-1:0]        addr_ff;
   logic                 ok_ff;
   logic [VALUE_W-1:0]   val_ff;
   logic [VALUE_W-1:0]   init_rd_ff;
   logic [DW-1:0]        delta_rd_ff;
   logic [VALUE_W-1:0]   base_ff;
   logic                 assigned_ff;
   logic [EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic [AW-1:0]        clr_cnt_ff;
   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_data_ff;

   logic [INDEX_W-1:0]   req_index;
   logic [OPERAND_W-1:0] req_operand;
   logic [AW-1:0]        req_addr;
   logic                 req_ok;
   logic                 delta_hit;
   logic [VALUE_W-1:0]   delta_cur;
   logic [VALUE_W-1:0]   base_cur;
   logic [VALUE_W-1:0]   add_sum;
   logic [VALUE_W-1:0]   query_sum;
   logic                 clear_last;
   logic                 dmem_we;
   logic [AW-1:0]        dmem_wa;
   logic [DW-1:0]        dmem_wd;
   logic                 exec_load;
   logic                 exec_assign;
   logic                 exec_add;
   logic                 exec_query;

   assign req_index   = req_tdata[INDEX_W+1:2];
   assign req_operand = req_tdata[OPERAND_W+INDEX_W+1:INDEX_W+2];
   assign req_addr    = AW'(req_index);
   assign req_ok      = 32'(req_index) < 32'(DEPTH);

   assign exec_load   = cmd.do_exec && op_ff == OP_LOAD;
   assign exec_assign = cmd.do_exec && op_ff == OP_ASSIGN;
   assign exec_add    = cmd.do_exec && op_ff == OP_ADD;
   assign exec_query  = cmd.do_exec && op_ff == OP_QUERY;

   assign delta_hit  = delta_rd_ff[DW-1:VALUE_W] == epoch_ff;
   assign delta_cur  = delta_hit ? delta_rd_ff[VALUE_W-1:0] : '0;
   assign base_cur   = assigned_ff ? base_ff : init_rd_ff;
   assign add_sum    = delta_cur + val_ff;
   assign query_sum  = ok_ff ? base_cur + delta_cur : '0;
   assign clear_last = clr_cnt_ff == AW'(DEPTH - 1);

   assign epoch_in = (epoch_ff == EPOCH_MAX) ? EPOCH_FIRST : epoch_ff + EPOCH_W'(1);

   always_comb begin
      dmem_we = 1'b0;
      dmem_wa = addr_ff;
      dmem_wd = {epoch_ff, add_sum};
      if (cmd.clear_step) begin
         dmem_we = 1'b1;
         dmem_wa = clr_cnt_ff;
         dmem_wd = {EPOCH_NONE, {VALUE_W{1'b0}}};
      end else if (exec_add && ok_ff) begin
         dmem_we = 1'b1;
      end
   end

   // memories: registered read at capture, one write port each
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         init_rd_ff  <= init_mem[req_addr];
         delta_rd_ff <= delta_mem[req_addr];
      end
      if (exec_load && ok_ff) begin
         init_mem[addr_ff] <= val_ff;
      end
      if (dmem_we) begin
         delta_mem[dmem_wa] <= dmem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= opcode_type'(req_tdata[1:0]);
         addr_ff <= req_addr;
         ok_ff   <= req_ok;
         val_ff  <= {{(VALUE_W-OPERAND_W){req_operand[OPERAND_W-1]}}, req_operand};
      end
      if (exec_query) begin
         rsp_data_ff <= query_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         assigned_ff  <= 1'b0;
         epoch_ff     <= EPOCH_FIRST;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec_assign) begin
            base_ff     <= val_ff;
            assigned_ff <= 1'b1;
            epoch_ff    <= epoch_in;
         end
         if (cmd.clear_step) begin
            clr_cnt_ff <= clear_last ? '0 : clr_cnt_ff + AW'(1);
         end
         if (exec_query) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.op         = op_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.clear_done = clear_last;
   assign status.epoch_wrap = epoch_ff == EPOCH_MAX;

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != EPOCH_NONE)
      else $error("epoch reached the invalid tag");

   a_query_result: assert property (@(posedge clock) disable iff (reset)
      exec_query |=> rsp_valid_ff && rsp_data_ff == $past(query_sum))
      else $error("query result not presented");

   a_assign_flag: assert property (@(posedge clock) disable iff (reset)
      exec_assign |=> assigned_ff && base_ff == $past(val_ff))
      else $error("assign-all not recorded");

endmodule

// File: rtl/array_assign_all_point_add_top.sv
// Top level of the bulk-assign / point-add table.
// Depends on aapa_pkg, aapa_ctrl and aapa_dp.
`timescale 1ns / 1ps
//
// channel   direction  ports              tdata fields (low bit up)
// req       in         req_tvalid/tready  opcode[1:0] index[11:2] operand_value[43:12]
// rsp       out        rsp_tvalid/tready  entry_value[63:0]
//
// Each item is accepted, then executed in the EXEC state after the registered
// memory read; no new item is accepted until it is done. A query waits in
// execute while the previous result is not taken. After reset, and after every
// 255th assign-all (epoch tag rollover), a clearing pass rewrites the delta
// tags; no item is accepted then. Reset is synchronous and active high.

module array_assign_all_point_add_top
   import aapa_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // opcode, index, operand_value, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_W-1:0]    rsp_tdata    // entry_value
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   aapa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   aapa_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
